// ----- src/pictc_pkg.sv -----
// ----------------------------------------------------------------------------
// pictc_pkg: shared types and constants for the PI controller
// Field widths, configuration register indexes and the symmetric clamp.
// ----------------------------------------------------------------------------
package pictc_pkg;

  localparam int unsigned DataW    = 32;  // Q20 ports
  localparam int unsigned ShiftQ   = 5;   // Q20 <-> Q15
  localparam int unsigned Q15W     = DataW - ShiftQ;  // Q15 view of a port
  localparam int unsigned GainW    = 31;
  localparam int unsigned LimitW   = 26;
  localparam int unsigned ErrW     = 28;  // Q15 error
  localparam int unsigned AccW     = 27;  // Q15 integrator and output
  localparam int unsigned WideW    = 45;  // clamp input width
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP         = 2'd0,
    CFG_INTEG_GAIN = 2'd1,
    CFG_INT_LIMIT  = 2'd2,
    CFG_OUT_LIMIT  = 2'd3
  } cfg_index_t;

  // Clamp v to [-lim, +lim]; the result always fits AccW bits.
  function automatic logic signed [AccW-1:0] clamp_sym(
    input logic signed [WideW-1:0] v,
    input logic [LimitW-1:0]       lim
  );
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    logic signed [AccW-1:0]  r;
    hi = $signed({{(WideW-LimitW){1'b0}}, lim});
    lo = -hi;
    priority if (v > hi) begin
      r = hi[AccW-1:0];
    end else if (v < lo) begin
      r = lo[AccW-1:0];
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/pi_controller_trapezoid_clamp.sv -----
// ----------------------------------------------------------------------------
// pi_controller_trapezoid_clamp: fixed-point PI controller
// Q20 setpoint and measurement in, clamped Q20 drive out. Trapezoidal
// integrator clamped to +/-int_limit, output clamped to +/-out_limit.
// A sample is registered in err_r, then in drive. Throughput: one transaction
// per cycle unless drive stalls; the integrator update (one multiply,
// add, clamp) closes its feedback loop within the compute stage.
// Reset (rst, synchronous): clears both valids, the integrator, the previous
// error and all four configuration registers.
// ----------------------------------------------------------------------------
module pi_controller_trapezoid_clamp (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [pictc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [pictc_pkg::GainW-1:0]       cfg_data,
  // sample channel
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  logic signed [pictc_pkg::DataW-1:0] target,
  input  logic signed [pictc_pkg::DataW-1:0] sensed,
  // drive channel
  output logic                              drive_valid,
  input  logic                              drive_ready,
  output logic signed [pictc_pkg::DataW-1:0] drive
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [pictc_pkg::GainW-1:0]  kp;
  logic [pictc_pkg::GainW-1:0]  integ_gain;
  logic [pictc_pkg::LimitW-1:0] int_limit;
  logic [pictc_pkg::LimitW-1:0] out_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp         <= '0;
      integ_gain <= '0;
      int_limit  <= '0;
      out_limit  <= '0;
    end else if (cfg_we) begin
      unique case (pictc_pkg::cfg_index_t'(cfg_index))
        pictc_pkg::CFG_KP:         kp         <= cfg_data;
        pictc_pkg::CFG_INTEG_GAIN: integ_gain <= cfg_data;
        pictc_pkg::CFG_INT_LIMIT:  int_limit  <= cfg_data[pictc_pkg::LimitW-1:0];
        pictc_pkg::CFG_OUT_LIMIT:  out_limit  <= cfg_data[pictc_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: Q20 -> Q15 is a floor shift, i.e. dropping the low bits.
  // The error is formed here so the compute stage starts from 28 bits.
  // --------------------------------------------------------------------------
  logic signed [pictc_pkg::Q15W-1:0] t15;
  logic signed [pictc_pkg::Q15W-1:0] s15;
  logic signed [pictc_pkg::ErrW-1:0] err_next;
  logic signed [pictc_pkg::ErrW-1:0] err_r;
  logic                              stage_valid;
  logic                              advance;

  assign t15      = target[pictc_pkg::DataW-1:pictc_pkg::ShiftQ];
  assign s15      = sensed[pictc_pkg::DataW-1:pictc_pkg::ShiftQ];
  assign err_next = {t15[pictc_pkg::Q15W-1], t15} - {s15[pictc_pkg::Q15W-1], s15};

  // The stage moves whenever the result register is empty or being drained,
  // so a new sample is taken every cycle unless the drive side stalls.
  assign advance      = stage_valid && (!drive_valid || drive_ready);
  assign sample_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_ready) begin
      stage_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      err_r <= err_next;
    end
  end

  // --------------------------------------------------------------------------
  // Compute stage
  // --------------------------------------------------------------------------
  logic signed [pictc_pkg::AccW-1:0] integral_acc;
  logic signed [pictc_pkg::ErrW-1:0] last_error;

  // Proportional: kp (Q15) * err (Q15) >> 15, 32x28 signed multiply.
  logic signed [pictc_pkg::GainW:0]   kp_s;
  logic signed [58:0]                 prod_p;
  logic signed [43:0]                 prop;

  assign kp_s   = $signed({1'b0, kp});
  assign prod_p = kp_s * err_r;
  assign prop   = prod_p[58:15];

  // Integrator step: integ_gain (Q20) * (err + last_err) >> 20, 32x29.
  logic signed [pictc_pkg::GainW:0]   ig_s;
  logic signed [pictc_pkg::ErrW:0]    esum;
  logic signed [60:0]                 prod_i;
  logic signed [40:0]                 step;

  assign ig_s   = $signed({1'b0, integ_gain});
  assign esum   = {err_r[pictc_pkg::ErrW-1], err_r}
                + {last_error[pictc_pkg::ErrW-1], last_error};
  assign prod_i = ig_s * esum;
  assign step   = prod_i[60:20];

  // Full-width sums ahead of each clamp, nothing wraps.
  logic signed [41:0]                   acc_sum;
  logic signed [pictc_pkg::AccW-1:0]    integral_acc_next;
  logic signed [pictc_pkg::WideW-1:0]   y_sum;
  logic signed [pictc_pkg::AccW-1:0]    y;
  logic signed [pictc_pkg::DataW-1:0]   drive_next;

  assign acc_sum = {step[40], step}
                 + {{(42 - pictc_pkg::AccW){integral_acc[pictc_pkg::AccW-1]}},
                    integral_acc};
  assign integral_acc_next = pictc_pkg::clamp_sym(
      {{(pictc_pkg::WideW - 42){acc_sum[41]}}, acc_sum}, int_limit);

  assign y_sum = {prop[43], prop}
               + {{(pictc_pkg::WideW - pictc_pkg::AccW){
                    integral_acc_next[pictc_pkg::AccW-1]}}, integral_acc_next};
  assign y     = pictc_pkg::clamp_sym(y_sum, out_limit);

  // Back to Q20; the clamped Q15 value is 27 bits, so this fills 32 exactly.
  assign drive_next = {y, {pictc_pkg::ShiftQ{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
      last_error   <= '0;
    end else if (advance) begin
      integral_acc <= integral_acc_next;
      last_error   <= err_r;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (advance) begin
      drive_valid <= 1'b1;
    end else if (drive_ready) begin
      drive_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive <= drive_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A held result must never be overwritten by the compute stage.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (drive_valid && !drive_ready) |-> !advance)
    else $error("compute stage advanced over a stalled result");

  // Every committed transaction shows up as a result on the next cycle.
  a_commit_to_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> drive_valid)
    else $error("committed transaction did not produce a result");

  // An empty compute stage must always accept a sample.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> sample_ready)
    else $error("sample channel stalled with empty compute stage");

  // The previous error only moves with a commit and then takes the stage error.
  a_last_error_tracks: assert property (@(posedge clk) disable iff (rst)
    $past(advance) |-> (last_error == $past(err_r)))
    else $error("previous error not updated from committed transaction");

  // Output is Q15 scaled to Q20, so the low bits are always clear.
  a_drive_aligned: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> (drive[pictc_pkg::ShiftQ-1:0] == '0))
    else $error("drive not aligned to Q15 step");

endmodule
